FILE: hw/rtl/lc3x_pkg.sv
`timescale 1ns / 1ps
package lc3x_pkg;

  localparam int MEM_WORDS = 65536;
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam int MAX_TEXT  = 64;
  localparam int NCH_W     = $clog2(MAX_TEXT + 1);

  localparam logic [15:0] KBSR = 16'hFE00;
  localparam logic [15:0] KBDR = 16'hFE02;

  localparam logic [2:0] MODE_MEM_WR = 3'd0;
  localparam logic [2:0] MODE_MEM_RD = 3'd1;
  localparam logic [2:0] MODE_STEP   = 3'd2;
  localparam logic [2:0] MODE_REG_RD = 3'd3;
  localparam logic [2:0] MODE_REG_WR = 3'd4;

  localparam logic [15:0] REG_IDX_PC   = 16'd8;
  localparam logic [15:0] REG_IDX_COND = 16'd9;

  localparam logic [3:0] OP_BR   = 4'd0;
  localparam logic [3:0] OP_ADD  = 4'd1;
  localparam logic [3:0] OP_LD   = 4'd2;
  localparam logic [3:0] OP_ST   = 4'd3;
  localparam logic [3:0] OP_JSR  = 4'd4;
  localparam logic [3:0] OP_AND  = 4'd5;
  localparam logic [3:0] OP_LDR  = 4'd6;
  localparam logic [3:0] OP_STR  = 4'd7;
  localparam logic [3:0] OP_NOT  = 4'd9;
  localparam logic [3:0] OP_LDI  = 4'd10;
  localparam logic [3:0] OP_STI  = 4'd11;
  localparam logic [3:0] OP_JMP  = 4'd12;
  localparam logic [3:0] OP_LEA  = 4'd14;
  localparam logic [3:0] OP_TRAP = 4'd15;

  localparam logic [7:0] TRAP_GETC  = 8'h20;
  localparam logic [7:0] TRAP_OUT   = 8'h21;
  localparam logic [7:0] TRAP_PUTS  = 8'h22;
  localparam logic [7:0] TRAP_IN    = 8'h23;
  localparam logic [7:0] TRAP_PUTSP = 8'h24;
  localparam logic [7:0] TRAP_HALT  = 8'h25;

  localparam logic [2:0] FLAG_N = 3'd4;
  localparam logic [2:0] FLAG_Z = 3'd2;
  localparam logic [2:0] FLAG_P = 3'd1;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] address;
    logic [15:0] data;
    logic        key_valid;
    logic [7:0]  key_char;
  } in_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [15:0] pc_after;
    logic        char_valid;
    logic [7:0]  out_char;
    logic        last;
    logic        halted;
    logic        text_cut;
  } out_t;

  typedef struct packed {
    logic              we;
    logic [MEM_AW-1:0] addr;
    logic [15:0]       wdata;
  } mem_req_t;

  typedef struct packed {
    logic [2:0]  raddr;
    logic        we;
    logic [2:0]  waddr;
    logic [15:0] wdata;
  } reg_req_t;

  function automatic logic [2:0] flags_of(input logic [15:0] v);
    if (v == 16'd0) return FLAG_Z;
    else if (v[15]) return FLAG_N;
    else return FLAG_P;
  endfunction

endpackage

FILE: hw/rtl/lc3x_mem.sv
`timescale 1ns / 1ps
module lc3x_mem import lc3x_pkg::*; (
  input  logic        clk,
  input  mem_req_t    req,
  output logic [15:0] rdata
);

  logic [15:0] mem [MEM_WORDS];
  logic [15:0] rdata_r;

  // one port, registered read, old data on same-address write
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata_r <= mem[req.addr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/lc3x_regfile.sv
`timescale 1ns / 1ps
module lc3x_regfile import lc3x_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  reg_req_t    req,
  output logic [15:0] rdata
);

  logic [15:0] regs [8];
  logic [7:0]  valid_r;
  logic [15:0] rdata_r;
  logic        rvalid_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      regs[req.waddr] <= req.wdata;
    end
    rdata_r <= regs[req.raddr];
  end

  // valid bits stand in for the all-zero reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 8'd0;
      rvalid_r <= 1'b0;
    end else begin
      if (req.we) begin
        valid_r[req.waddr] <= 1'b1;
      end
      rvalid_r <= valid_r[req.raddr];
    end
  end

  assign rdata = rvalid_r ? rdata_r : 16'd0;

endmodule

FILE: hw/rtl/lc3_instruction_executor.sv
`timescale 1ns / 1ps
// channel   ports                          moves
// input     start, busy, in_item           one command transaction (mode, address, data, key)
// result    out_strobe, out_item           one result per strobe cycle, 1 to MAX_TEXT per command
//
// steps: an instruction step runs fetch, two register-file reads and execute, plus extra
// loads through the single memory port; string traps read memory one word at a time
// reset: rst_n synchronous; pc 0x3000, flags Z, running; memory undefined until written
// stalls: busy is high from acceptance until the final result is strobed; the receiver
// cannot stall, results appear one per strobe cycle
module lc3_instruction_executor import lc3x_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_item,
  output logic out_strobe,
  output out_t out_item
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DISP    = 5'd1;
  localparam logic [4:0] S_LDREQ   = 5'd2;
  localparam logic [4:0] S_LDWAIT  = 5'd3;
  localparam logic [4:0] S_LDKB    = 5'd4;
  localparam logic [4:0] S_MRD     = 5'd5;
  localparam logic [4:0] S_RREG    = 5'd6;
  localparam logic [4:0] S_FETCHED = 5'd7;
  localparam logic [4:0] S_RDA     = 5'd8;
  localparam logic [4:0] S_RDB     = 5'd9;
  localparam logic [4:0] S_EXE     = 5'd10;
  localparam logic [4:0] S_LDDONE  = 5'd11;
  localparam logic [4:0] S_LDI2    = 5'd12;
  localparam logic [4:0] S_STI2    = 5'd13;
  localparam logic [4:0] S_TRAPK   = 5'd14;
  localparam logic [4:0] S_SREQ    = 5'd15;
  localparam logic [4:0] S_SWAIT   = 5'd16;
  localparam logic [4:0] S_SHI     = 5'd17;

  logic [4:0]       state_r, state_nxt;
  logic [4:0]       ret_r, ret_nxt;
  in_t              cmd_r, cmd_nxt;
  logic [15:0]      pc_r, pc_nxt;
  logic [2:0]       cond_r, cond_nxt;
  logic             run_r, run_nxt;
  logic [15:0]      ld_addr_r, ld_addr_nxt;
  logic [15:0]      ld_val_r, ld_val_nxt;
  logic [15:0]      ins_r, ins_nxt;
  logic [15:0]      a_r, a_nxt;
  logic [15:0]      b_r, b_nxt;
  logic [15:0]      p_r, p_nxt;
  logic [7:0]       hi_r, hi_nxt;
  logic [NCH_W-1:0] nch_r, nch_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic [7:0]       pend_c_r, pend_c_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_r, out_nxt;

  mem_req_t    mreq;
  reg_req_t    rreq;
  logic [15:0] mem_rdata;
  logic [15:0] reg_rdata;

  lc3x_mem u_mem (
    .clk   (clk),
    .req   (mreq),
    .rdata (mem_rdata)
  );

  lc3x_regfile u_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rreq),
    .rdata (reg_rdata)
  );

  // decoded fields of the held instruction
  logic [15:0] off9, off6, off11, imm5, opb, alu_v;
  logic [2:0]  dr;
  logic        at_max;

  assign off9   = {{7{ins_r[8]}}, ins_r[8:0]};
  assign off6   = {{10{ins_r[5]}}, ins_r[5:0]};
  assign off11  = {{5{ins_r[10]}}, ins_r[10:0]};
  assign imm5   = {{11{ins_r[4]}}, ins_r[4:0]};
  assign opb    = ins_r[5] ? imm5 : b_r;
  assign dr     = ins_r[11:9];
  assign at_max = (nch_r == NCH_W'(MAX_TEXT));

  logic        emit, e_last, e_cv, e_cut;
  logic [15:0] e_rd;
  logic [7:0]  e_ch;

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    cmd_nxt       = cmd_r;
    pc_nxt        = pc_r;
    cond_nxt      = cond_r;
    run_nxt       = run_r;
    ld_addr_nxt   = ld_addr_r;
    ld_val_nxt    = ld_val_r;
    ins_nxt       = ins_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    p_nxt         = p_r;
    hi_nxt        = hi_r;
    nch_nxt       = nch_r;
    pend_v_nxt    = pend_v_r;
    pend_c_nxt    = pend_c_r;
    mreq          = '0;
    rreq          = '0;
    emit          = 1'b0;
    e_last        = 1'b0;
    e_cv          = pend_v_r;
    e_ch          = pend_c_r;
    e_cut         = 1'b0;
    e_rd          = ins_r;
    alu_v         = 16'd0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt    = in_item;
          pend_v_nxt = 1'b0;
          nch_nxt    = '0;
          state_nxt  = S_DISP;
        end
      end

      S_DISP: begin
        // finish unless a branch below starts a longer sequence
        emit      = 1'b1;
        e_last    = 1'b1;
        e_rd      = 16'd0;
        state_nxt = S_IDLE;
        case (cmd_r.mode)
          MODE_MEM_WR: begin
            mreq.we    = 1'b1;
            mreq.addr  = cmd_r.address[MEM_AW-1:0];
            mreq.wdata = cmd_r.data;
          end
          MODE_MEM_RD: begin
            emit        = 1'b0;
            ld_addr_nxt = cmd_r.address;
            ret_nxt     = S_MRD;
            state_nxt   = S_LDREQ;
          end
          MODE_REG_RD: begin
            if (cmd_r.address < REG_IDX_PC) begin
              emit       = 1'b0;
              rreq.raddr = cmd_r.address[2:0];
              state_nxt  = S_RREG;
            end else if (cmd_r.address == REG_IDX_PC) begin
              e_rd = pc_r;
            end else if (cmd_r.address == REG_IDX_COND) begin
              e_rd = {13'd0, cond_r};
            end
          end
          MODE_REG_WR: begin
            if (cmd_r.address < REG_IDX_PC) begin
              rreq.we    = 1'b1;
              rreq.waddr = cmd_r.address[2:0];
              rreq.wdata = cmd_r.data;
            end else if (cmd_r.address == REG_IDX_PC) begin
              pc_nxt  = cmd_r.data;
              run_nxt = 1'b1;
            end else if (cmd_r.address == REG_IDX_COND) begin
              cond_nxt = cmd_r.data[2:0];
            end
          end
          MODE_STEP: begin
            if (run_r) begin
              emit        = 1'b0;
              ld_addr_nxt = pc_r;
              ret_nxt     = S_FETCHED;
              state_nxt   = S_LDREQ;
            end
          end
          default: begin
          end
        endcase
      end

      // load with keyboard status refresh, returns to ret_r with ld_val_r
      S_LDREQ: begin
        if (ld_addr_r == KBSR) begin
          mreq.we    = 1'b1;
          mreq.addr  = KBSR[MEM_AW-1:0];
          mreq.wdata = cmd_r.key_valid ? 16'h8000 : 16'h0000;
          ld_val_nxt = mreq.wdata;
          state_nxt  = cmd_r.key_valid ? S_LDKB : ret_r;
        end else begin
          mreq.addr = ld_addr_r[MEM_AW-1:0];
          state_nxt = S_LDWAIT;
        end
      end

      S_LDWAIT: begin
        ld_val_nxt = mem_rdata;
        state_nxt  = ret_r;
      end

      S_LDKB: begin
        mreq.we    = 1'b1;
        mreq.addr  = KBDR[MEM_AW-1:0];
        mreq.wdata = {8'd0, cmd_r.key_char};
        state_nxt  = ret_r;
      end

      S_MRD: begin
        emit      = 1'b1;
        e_last    = 1'b1;
        e_rd      = ld_val_r;
        state_nxt = S_IDLE;
      end

      S_RREG: begin
        emit      = 1'b1;
        e_last    = 1'b1;
        e_rd      = reg_rdata;
        state_nxt = S_IDLE;
      end

      S_FETCHED: begin
        ins_nxt    = ld_val_r;
        pc_nxt     = pc_r + 16'd1;
        rreq.raddr = ld_val_r[8:6];
        state_nxt  = S_RDA;
      end

      S_RDA: begin
        a_nxt = reg_rdata;
        // stores need the source register, traps need r0
        if (ins_r[15:12] == OP_ST || ins_r[15:12] == OP_STR || ins_r[15:12] == OP_STI) begin
          rreq.raddr = dr;
        end else if (ins_r[15:12] == OP_TRAP) begin
          rreq.raddr = 3'd0;
        end else begin
          rreq.raddr = ins_r[2:0];
        end
        state_nxt = S_RDB;
      end

      S_RDB: begin
        b_nxt     = reg_rdata;
        state_nxt = S_EXE;
      end

      S_EXE: begin
        emit      = 1'b1;
        e_last    = 1'b1;
        state_nxt = S_IDLE;
        case (ins_r[15:12])
          OP_BR: begin
            if (|(ins_r[11:9] & cond_r)) pc_nxt = pc_r + off9;
          end
          OP_ADD, OP_AND, OP_NOT, OP_LEA: begin
            if (ins_r[15:12] == OP_ADD) alu_v = a_r + opb;
            else if (ins_r[15:12] == OP_AND) alu_v = a_r & opb;
            else if (ins_r[15:12] == OP_NOT) alu_v = ~a_r;
            else alu_v = pc_r + off9;
            rreq.we    = 1'b1;
            rreq.waddr = dr;
            rreq.wdata = alu_v;
            cond_nxt   = flags_of(alu_v);
          end
          OP_LD, OP_LDR, OP_LDI, OP_STI: begin
            emit        = 1'b0;
            ld_addr_nxt = (ins_r[15:12] == OP_LDR) ? a_r + off6 : pc_r + off9;
            if (ins_r[15:12] == OP_LDI) ret_nxt = S_LDI2;
            else if (ins_r[15:12] == OP_STI) ret_nxt = S_STI2;
            else ret_nxt = S_LDDONE;
            state_nxt = S_LDREQ;
          end
          OP_ST, OP_STR: begin
            mreq.we    = 1'b1;
            mreq.addr  = (ins_r[15:12] == OP_STR) ? MEM_AW'(a_r + off6)
                                                  : MEM_AW'(pc_r + off9);
            mreq.wdata = b_r;
          end
          OP_JSR: begin
            rreq.we    = 1'b1;
            rreq.waddr = 3'd7;
            rreq.wdata = pc_r;
            pc_nxt     = ins_r[11] ? pc_r + off11 : a_r;
          end
          OP_JMP: begin
            pc_nxt = a_r;
          end
          OP_TRAP: begin
            rreq.we    = 1'b1;
            rreq.waddr = 3'd7;
            rreq.wdata = pc_r;
            case (ins_r[7:0])
              TRAP_GETC, TRAP_IN: begin
                emit      = 1'b0;
                state_nxt = S_TRAPK;
              end
              TRAP_OUT: begin
                e_cv = 1'b1;
                e_ch = b_r[7:0];
              end
              TRAP_PUTS, TRAP_PUTSP: begin
                emit      = 1'b0;
                p_nxt     = b_r;
                state_nxt = S_SREQ;
              end
              TRAP_HALT: begin
                run_nxt = 1'b0;
              end
              default: begin
              end
            endcase
          end
          default: begin
          end
        endcase
      end

      S_LDDONE: begin
        rreq.we    = 1'b1;
        rreq.waddr = dr;
        rreq.wdata = ld_val_r;
        cond_nxt   = flags_of(ld_val_r);
        emit       = 1'b1;
        e_last     = 1'b1;
        state_nxt  = S_IDLE;
      end

      S_LDI2: begin
        ld_addr_nxt = ld_val_r;
        ret_nxt     = S_LDDONE;
        state_nxt   = S_LDREQ;
      end

      S_STI2: begin
        mreq.we    = 1'b1;
        mreq.addr  = ld_val_r[MEM_AW-1:0];
        mreq.wdata = b_r;
        emit       = 1'b1;
        e_last     = 1'b1;
        state_nxt  = S_IDLE;
      end

      S_TRAPK: begin
        rreq.we    = 1'b1;
        rreq.waddr = 3'd0;
        rreq.wdata = cmd_r.key_valid ? {8'd0, cmd_r.key_char} : 16'd0;
        emit       = 1'b1;
        e_last     = 1'b1;
        state_nxt  = S_IDLE;
      end

      // string loop: one character held back so the final one carries last
      S_SREQ: begin
        mreq.addr = p_r[MEM_AW-1:0];
        state_nxt = S_SWAIT;
      end

      S_SWAIT: begin
        if (mem_rdata == 16'd0) begin
          emit      = 1'b1;
          e_last    = 1'b1;
          state_nxt = S_IDLE;
        end else if (at_max) begin
          emit      = 1'b1;
          e_last    = 1'b1;
          e_cut     = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          emit       = pend_v_r;
          pend_v_nxt = 1'b1;
          pend_c_nxt = mem_rdata[7:0];
          nch_nxt    = nch_r + NCH_W'(1);
          if (ins_r[7:0] == TRAP_PUTSP && mem_rdata[15:8] != 8'd0) begin
            hi_nxt    = mem_rdata[15:8];
            state_nxt = S_SHI;
          end else begin
            p_nxt     = p_r + 16'd1;
            state_nxt = S_SREQ;
          end
        end
      end

      S_SHI: begin
        if (at_max) begin
          emit      = 1'b1;
          e_last    = 1'b1;
          e_cut     = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          emit       = pend_v_r;
          pend_c_nxt = hi_r;
          nch_nxt    = nch_r + NCH_W'(1);
          p_nxt      = p_r + 16'd1;
          state_nxt  = S_SREQ;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // result fields take the architectural state as it stands after this cycle
    out_valid_nxt      = emit;
    out_nxt.read_data  = e_rd;
    out_nxt.pc_after   = pc_nxt;
    out_nxt.char_valid = e_cv;
    out_nxt.out_char   = e_cv ? e_ch : 8'd0;
    out_nxt.last       = e_last;
    out_nxt.halted     = ~run_nxt;
    out_nxt.text_cut   = e_cut;
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= 16'h3000;
      cond_r      <= FLAG_Z;
      run_r       <= 1'b1;
      out_valid_r <= 1'b0;
      nch_r       <= '0;
      pend_v_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      cond_r      <= cond_nxt;
      run_r       <= run_nxt;
      out_valid_r <= out_valid_nxt;
      nch_r       <= nch_nxt;
      pend_v_r    <= pend_v_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    ret_r     <= ret_nxt;
    cmd_r     <= cmd_nxt;
    ld_addr_r <= ld_addr_nxt;
    ld_val_r  <= ld_val_nxt;
    ins_r     <= ins_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    p_r       <= p_nxt;
    hi_r      <= hi_nxt;
    pend_c_r  <= pend_c_nxt;
    out_r     <= out_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_valid_r;
  assign out_item   = out_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_cut_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.text_cut |-> out_item.last)
    else $error("text cut flagged on a non-final result");

  a_nch_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nch_r <= NCH_W'(MAX_TEXT))
    else $error("character count beyond limit");

  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !busy |-> out_item.last)
    else $error("block idle before final result");

endmodule

FILE: sim/lc3_exec_checker.sv
`timescale 1ns / 1ps
module lc3_exec_checker import lc3x_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  in_t         in_item,
  input  logic        out_strobe,
  input  out_t        out_item,
  input  logic        done,
  output int unsigned fail_count,
  output int unsigned pending
);

  logic [15:0] mem_shadow [0:MEM_WORDS-1];
  logic [15:0] gpr [0:7];
  logic [15:0] pc_q;
  logic [2:0]  flags_q;
  logic        running;
  out_t        expected_results [$];
  bit          done_seen;

  assign pending = expected_results.size();

  function automatic logic [15:0] sx(input logic [15:0] v, input int bits);
    logic [15:0] r;
    r = v;
    for (int i = bits; i < 16; i++) r[i] = v[bits-1];
    return r;
  endfunction

  function automatic logic [2:0] nzp(input logic [15:0] v);
    if (v == 16'd0) return FLAG_Z;
    if (v[15]) return FLAG_N;
    return FLAG_P;
  endfunction

  // keyboard status read refreshes the status word, and the data word when a key is valid, first
  function automatic logic [15:0] load_word(input logic [15:0] a, input logic kv,
                                            input logic [7:0] kc);
    if (a == KBSR) begin
      mem_shadow[KBSR] = kv ? 16'h8000 : 16'h0000;
      if (kv) mem_shadow[KBDR] = {8'h00, kc};
    end
    return mem_shadow[a];
  endfunction

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    fail_count++;
  endtask

  task automatic execute_command(input in_t it);
    logic [15:0] rd, ins, pcn, off9, off6, opb, t, p, w;
    logic [2:0]  dr, sr;
    logic [7:0]  vec;
    logic [7:0]  chars [$];
    logic        cut;
    out_t        r;
    rd = '0;
    cut = 1'b0;
    chars = {};
    case (it.mode)
      MODE_MEM_WR: mem_shadow[it.address] = it.data;
      MODE_MEM_RD: rd = load_word(it.address, it.key_valid, it.key_char);
      MODE_REG_RD: begin
        if (it.address < 8) rd = gpr[it.address[2:0]];
        else if (it.address == REG_IDX_PC) rd = pc_q;
        else if (it.address == REG_IDX_COND) rd = {13'd0, flags_q};
      end
      MODE_REG_WR: begin
        if (it.address < 8) gpr[it.address[2:0]] = it.data;
        else if (it.address == REG_IDX_PC) begin
          pc_q = it.data;
          running = 1'b1;
        end else if (it.address == REG_IDX_COND) flags_q = it.data[2:0];
      end
      MODE_STEP: if (running) begin
        ins  = load_word(pc_q, it.key_valid, it.key_char);
        dr   = ins[11:9];
        sr   = ins[8:6];
        off9 = sx(ins & 16'h01FF, 9);
        off6 = sx(ins & 16'h003F, 6);
        opb  = ins[5] ? sx(ins & 16'h001F, 5) : gpr[ins[2:0]];
        pc_q = pc_q + 16'd1;
        pcn  = pc_q;
        rd   = ins;
        case (ins[15:12])
          OP_BR: if (ins[11:9] & flags_q) pc_q = pcn + off9;
          OP_ADD: begin
            gpr[dr] = gpr[sr] + opb;
            flags_q = nzp(gpr[dr]);
          end
          OP_LD: begin
            gpr[dr] = load_word(pcn + off9, it.key_valid, it.key_char);
            flags_q = nzp(gpr[dr]);
          end
          OP_ST: mem_shadow[pcn + off9] = gpr[dr];
          OP_JSR: begin
            t = gpr[sr];
            gpr[7] = pcn;
            pc_q = ins[11] ? pcn + sx(ins & 16'h07FF, 11) : t;
          end
          OP_AND: begin
            gpr[dr] = gpr[sr] & opb;
            flags_q = nzp(gpr[dr]);
          end
          OP_LDR: begin
            gpr[dr] = load_word(gpr[sr] + off6, it.key_valid, it.key_char);
            flags_q = nzp(gpr[dr]);
          end
          OP_STR: mem_shadow[gpr[sr] + off6] = gpr[dr];
          OP_NOT: begin
            gpr[dr] = ~gpr[sr];
            flags_q = nzp(gpr[dr]);
          end
          OP_LDI: begin
            t = load_word(pcn + off9, it.key_valid, it.key_char);
            gpr[dr] = load_word(t, it.key_valid, it.key_char);
            flags_q = nzp(gpr[dr]);
          end
          OP_STI: begin
            t = load_word(pcn + off9, it.key_valid, it.key_char);
            mem_shadow[t] = gpr[dr];
          end
          OP_JMP: pc_q = gpr[sr];
          OP_LEA: begin
            gpr[dr] = pcn + off9;
            flags_q = nzp(gpr[dr]);
          end
          OP_TRAP: begin
            vec = ins[7:0];
            p = gpr[0];
            gpr[7] = pcn;
            if (vec == TRAP_GETC || vec == TRAP_IN) begin
              gpr[0] = it.key_valid ? {8'h00, it.key_char} : 16'h0000;
            end else if (vec == TRAP_OUT) begin
              chars.push_back(gpr[0][7:0]);
            end else if (vec == TRAP_PUTS || vec == TRAP_PUTSP) begin
              // string traps peek memory without the keyboard refresh
              forever begin
                w = mem_shadow[p];
                if (w == 16'd0) break;
                if (chars.size() == MAX_TEXT) begin
                  cut = 1'b1;
                  break;
                end
                chars.push_back(w[7:0]);
                if (vec == TRAP_PUTSP && w[15:8] != 8'd0) begin
                  if (chars.size() == MAX_TEXT) begin
                    cut = 1'b1;
                    break;
                  end
                  chars.push_back(w[15:8]);
                end
                p = p + 16'd1;
              end
            end else if (vec == TRAP_HALT) begin
              running = 1'b0;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    r = '0;
    r.read_data = rd;
    r.pc_after  = pc_q;
    r.halted    = !running;
    if (chars.size() == 0) begin
      r.last = 1'b1;
      expected_results.push_back(r);
    end else begin
      foreach (chars[k]) begin
        r.char_valid = 1'b1;
        r.out_char   = chars[k];
        r.last       = (k == chars.size() - 1);
        r.text_cut   = r.last && cut;
        expected_results.push_back(r);
      end
    end
  endtask

  initial begin
    fail_count = 0;
    done_seen  = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (gpr[i]) gpr[i] = '0;
      pc_q    = 16'h3000;
      flags_q = FLAG_Z;
      running = 1'b1;
      expected_results = {};
    end else begin
      if (out_strobe) begin
        if (expected_results.size() == 0) begin
          report("unexpected result, read_data", out_item.read_data, 16'hxxxx);
        end else begin
          out_t e;
          e = expected_results.pop_front();
          if (out_item.read_data !== e.read_data)
            report("read_data", out_item.read_data, e.read_data);
          if (out_item.pc_after !== e.pc_after)
            report("pc_after", out_item.pc_after, e.pc_after);
          if (out_item.char_valid !== e.char_valid)
            report("char_valid", out_item.char_valid, e.char_valid);
          if (out_item.out_char !== e.out_char)
            report("out_char", out_item.out_char, e.out_char);
          if (out_item.last !== e.last) report("last", out_item.last, e.last);
          if (out_item.halted !== e.halted) report("halted", out_item.halted, e.halted);
          if (out_item.text_cut !== e.text_cut)
            report("text_cut", out_item.text_cut, e.text_cut);
        end
      end
      if (start && !busy) execute_command(in_item);
      if (done && !done_seen) begin
        done_seen = 1'b1;
        if (expected_results.size() != 0)
          report("results never arrived, count", expected_results.size(), 16'd0);
      end
    end
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import lc3x_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int          RANDOM_ITEMS = 360;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_t         in_item;
  logic        out_strobe;
  out_t        out_item;
  logic        done;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count;
  int          items_sent;
  bit          quiet_tail;

  lc3_instruction_executor u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  // checker watches both channels, predicts and compares
  lc3_exec_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item),
    .done      (done),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog, sized for a full memory fill plus many long string traps
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // one command transaction; called at a rising edge, returns at the edge that takes it
  task automatic issue(input in_t it, input bit may_idle);
    if (may_idle && !quiet_tail && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  function automatic in_t cmd(input logic [2:0] m, input logic [15:0] a, input logic [15:0] d);
    in_t it;
    it.mode      = m;
    it.address   = a;
    it.data      = d;
    it.key_valid = $urandom_range(0, 1);
    it.key_char  = $urandom_range(0, 255);
    return it;
  endfunction

  // random but mostly sensible instruction word, traps biased to the real vectors
  function automatic logic [15:0] rand_instr();
    logic [15:0] w;
    w = $urandom_range(0, 16'hFFFF);
    if (w[15:12] == OP_TRAP) begin
      w[11:8] = 4'h0;
      if ($urandom_range(0, 5) != 0) w[7:0] = TRAP_GETC + $urandom_range(0, 5);
    end
    return w;
  endfunction

  // lay a program down, point pc at it and step through
  task automatic run_program(input logic [15:0] base, input logic [15:0] words [$],
                             input int extra_steps, input bit may_idle);
    foreach (words[i]) issue(cmd(MODE_MEM_WR, base + i, words[i]), may_idle);
    issue(cmd(MODE_REG_WR, REG_IDX_PC, base), may_idle);
    repeat (words.size() + extra_steps) issue(cmd(MODE_STEP, 16'h0, 16'h0), may_idle);
  endtask

  // short terminated string at s, r0 pointing at it
  task automatic plant_string(input logic [15:0] s, input bit may_idle);
    int n;
    logic [15:0] w;
    n = $urandom_range(0, 5);
    for (int i = 0; i < n; i++) begin
      w = $urandom_range(1, 16'hFFFF);
      if ($urandom_range(0, 2) == 0) w[15:8] = 8'h00;
      if (w == 16'd0) w = 16'h0041;
      issue(cmd(MODE_MEM_WR, s + i, w), may_idle);
    end
    issue(cmd(MODE_MEM_WR, s + n, 16'h0000), may_idle);
    issue(cmd(MODE_REG_WR, 16'd0, s), may_idle);
  endtask

  task automatic wait_quiet();
    start <= 1'b0;
    do @(posedge clk); while (busy || pending != 0);
  endtask

  initial begin
    logic [15:0] prog [$];
    in_t         it;
    int          r;
    logic [15:0] base;

    start      = 1'b0;
    in_item    = '0;
    done       = 1'b0;
    rst_n      = 1'b0;
    items_sent = 0;
    quiet_tail = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill every word first so that no read ever lands on an unwritten entry;
    // a quarter are zero so random strings end now and then
    for (int a = 0; a < MEM_WORDS; a++) begin
      issue(cmd(MODE_MEM_WR, a[15:0],
                ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom_range(0, 16'hFFFF))),
            1'b0);
    end

    // directed: field extremes, register index corners, keyboard refresh
    it = cmd(MODE_MEM_WR, 16'hFFFF, 16'hFFFF);
    it.key_valid = 1'b0;
    it.key_char  = 8'h00;
    issue(it, 1'b1);
    issue(cmd(MODE_MEM_RD, 16'hFFFF, 16'h0), 1'b1);
    issue(cmd(MODE_MEM_WR, 16'h0000, 16'h0000), 1'b1);
    it = cmd(MODE_MEM_RD, KBSR, 16'h0);
    it.key_valid = 1'b1;
    it.key_char  = 8'hFF;
    issue(it, 1'b1);
    issue(cmd(MODE_MEM_RD, KBDR, 16'h0), 1'b1);
    it.key_valid = 1'b0;
    issue(it, 1'b1);
    issue(cmd(MODE_REG_WR, REG_IDX_COND, 16'hFFFF), 1'b1);
    issue(cmd(MODE_REG_RD, REG_IDX_COND, 16'h0), 1'b1);
    issue(cmd(MODE_REG_WR, 16'hFFFF, 16'h1234), 1'b1);
    issue(cmd(MODE_REG_RD, 16'd10, 16'h0), 1'b1);
    issue(cmd(MODE_REG_WR, 16'd1, 16'hFFFF), 1'b1);
    for (int m = 5; m < 8; m++) issue(cmd(m[2:0], 16'hFFFF, 16'hFFFF), 1'b1);

    // every opcode and every trap vector; the jsr/jmp pair then loops, so the final halt is never stepped
    prog = {16'h127F, 16'h5441, 16'h96BF, 16'h0E00, 16'h29FF, 16'h3801,
            16'h6A40, 16'h7A81, 16'hAC00, 16'hBC00, 16'hE1FF, 16'h8000,
            16'hD000, 16'hF021, 16'hF020, 16'hF023, 16'hF022, 16'hF024,
            16'hF0FF, 16'h4801, 16'h0000, 16'hC1C0, 16'hF025};
    run_program(16'h3000, prog, 2, 1'b1);
    // jsrr, and a terminated string through putsp and puts
    plant_string(16'h4000, 1'b1);
    run_program(16'h3100, '{16'hF024, 16'hF022, 16'h4040}, 1, 1'b1);
    issue(cmd(MODE_REG_RD, REG_IDX_PC, 16'h0), 1'b1);

    // random: short programs with random content, plus noise commands
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent > RANDOM_ITEMS - 40) quiet_tail = 1'b1;
      // around the halfway mark, let everything drain before carrying on
      if (items_sent > RANDOM_ITEMS / 2 && items_sent < RANDOM_ITEMS / 2 + 4) wait_quiet();
      r = $urandom_range(0, 9);
      if (r < 6) begin
        prog = {};
        repeat ($urandom_range(2, 6)) prog.push_back(rand_instr());
        base = $urandom_range(0, 16'hFFFF);
        if ($urandom_range(0, 1) == 0) plant_string(base ^ 16'h8000, 1'b1);
        run_program(base, prog, $urandom_range(0, 2), 1'b1);
      end else begin
        it = cmd($urandom_range(0, 7), $urandom_range(0, 16'hFFFF),
                 $urandom_range(0, 16'hFFFF));
        if (it.mode == MODE_REG_RD || it.mode == MODE_REG_WR)
          if ($urandom_range(0, 3) != 0) it.address = $urandom_range(0, 11);
        if (it.mode == MODE_MEM_RD && $urandom_range(0, 4) == 0) it.address = KBSR;
        issue(it, 1'b1);
      end
    end

    // drain, then allow a little slack for any stray strobe
    wait_quiet();
    repeat (40) @(posedge clk);
    done <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
